[sv/chb_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// chb_pkg
// Types, constants and helpers shared by the chunked body decoder.
// ============================================================================
package chb_pkg;

    // Widest chunk size, in bits
    localparam int SIZE_BITS = 32;

    // Characters of the size line
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    // Status codes shown on each result
    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // Line length saturates here
    localparam logic [1:0] LINE_LEN_MAX = 2'd2;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_DATA,
        PH_SKIP,
        PH_DONE,
        PH_ERR
    } t_phase;

    typedef logic [SIZE_BITS-1:0] t_size;

    // One request on the input side
    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_body;
    } t_item;

    // One result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       payload_valid;
        logic       chunk_last;
        logic [1:0] status;
    } t_result;

    // Hex digit decode: valid flag and nibble
    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.nib = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.nib = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.nib = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

[sv/chb_ifs.sv]
`timescale 1ns / 1ps
// ============================================================================
// chb_in_if / chb_out_if
// Valid/ready channels for body bytes in and decoded results out.
// ============================================================================
interface chb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       new_body;

    modport source (output valid, in_byte, new_body, input ready);
    modport sink   (input valid, in_byte, new_body, output ready);
endinterface

interface chb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       payload_valid;
    logic       chunk_last;
    logic [1:0] status;

    modport source (output valid, out_byte, payload_valid, chunk_last, status,
                    input ready);
    modport sink   (input valid, out_byte, payload_valid, chunk_last, status,
                    output ready);
endinterface

[sv/chb_in_stage.sv]
`timescale 1ns / 1ps
// ============================================================================
// chb_in_stage
// Input register: holds one request until the parser consumes it.
// ============================================================================
module chb_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    chb_in_if.sink        i_in,
    input  logic          i_advance,
    output logic          o_valid,
    output chb_pkg::t_item o_item
);
    import chb_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  accept;

    // Refill in the same cycle the held request moves on
    assign i_in.ready = !r_valid || i_advance;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.in_byte  <= i_in.in_byte;
            r_item.new_body <= i_in.new_body;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[sv/chb_parser.sv]
`timescale 1ns / 1ps
// ============================================================================
// chb_parser
// Chunk framing state and the per-byte update that forms each result.
// ============================================================================
module chb_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  chb_pkg::t_item   i_item,
    output chb_pkg::t_result o_result
);
    import chb_pkg::*;

    t_phase     r_phase,     n_phase;
    t_size      r_accum,     n_accum;
    logic [1:0] r_line_len,  n_line_len;
    logic       r_only_zero, n_only_zero;
    logic       r_seen_cr,   n_seen_cr;
    logic       r_line_bad,  n_line_bad;
    t_size      r_remaining, n_remaining;
    logic       r_skip,      n_skip;

    // State register, updated once per consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIZE;
            r_accum     <= '0;
            r_line_len  <= '0;
            r_only_zero <= 1'b0;
            r_seen_cr   <= 1'b0;
            r_line_bad  <= 1'b0;
            r_remaining <= '0;
            r_skip      <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_accum     <= n_accum;
            r_line_len  <= n_line_len;
            r_only_zero <= n_only_zero;
            r_seen_cr   <= n_seen_cr;
            r_line_bad  <= n_line_bad;
            r_remaining <= n_remaining;
            r_skip      <= n_skip;
        end
    end

    // Next state and result for the byte at the input register
    always_comb begin
        logic [7:0] c;
        t_hex       h;
        logic       pv;
        logic       last;

        c    = i_item.in_byte;
        h    = hex_decode(c);
        pv   = 1'b0;
        last = 1'b0;

        n_phase     = r_phase;
        n_accum     = r_accum;
        n_line_len  = r_line_len;
        n_only_zero = r_only_zero;
        n_seen_cr   = r_seen_cr;
        n_line_bad  = r_line_bad;
        n_remaining = r_remaining;
        n_skip      = r_skip;

        // New body: start from the reset state
        if (i_item.new_body) begin
            n_phase     = PH_SIZE;
            n_accum     = '0;
            n_line_len  = '0;
            n_only_zero = 1'b0;
            n_seen_cr   = 1'b0;
            n_line_bad  = 1'b0;
            n_remaining = '0;
            n_skip      = 1'b0;
        end

        unique case (n_phase)
            PH_SIZE: begin
                if (n_seen_cr && c == CHAR_LF) begin
                    // CR LF closes the size line
                    if (n_line_len == '0 || n_line_bad) begin
                        n_phase = PH_ERR;
                    end else if (n_only_zero) begin
                        n_phase = PH_DONE;
                    end else if (n_accum == '0) begin
                        n_phase = PH_ERR;
                    end else begin
                        n_remaining = n_accum;
                        n_phase     = PH_DATA;
                    end
                    n_accum     = '0;
                    n_line_len  = '0;
                    n_only_zero = 1'b0;
                    n_seen_cr   = 1'b0;
                    n_line_bad  = 1'b0;
                end else begin
                    // CR without LF taints the line
                    if (n_seen_cr) begin
                        n_line_bad = 1'b1;
                    end
                    if (c == CHAR_CR) begin
                        n_seen_cr = 1'b1;
                    end else begin
                        n_seen_cr   = 1'b0;
                        n_only_zero = (n_line_len == '0) && (c == CHAR_ZERO);
                        if (n_line_len != LINE_LEN_MAX) begin
                            n_line_len = n_line_len + 2'd1;
                        end
                        if (!h.ok) begin
                            n_line_bad = 1'b1;
                        end else if (n_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
                            n_line_bad = 1'b1;
                        end else begin
                            n_accum = {n_accum[SIZE_BITS-5:0], h.nib};
                        end
                    end
                end
            end
            PH_DATA: begin
                pv = 1'b1;
                if (n_remaining != '0) begin
                    n_remaining = n_remaining - t_size'(1);
                end
                if (n_remaining == '0) begin
                    last    = 1'b1;
                    n_phase = PH_SKIP;
                    n_skip  = 1'b0;
                end
            end
            PH_SKIP: begin
                // Two trailing bytes after the data, not checked
                if (n_skip) begin
                    n_skip      = 1'b0;
                    n_phase     = PH_SIZE;
                    n_accum     = '0;
                    n_line_len  = '0;
                    n_only_zero = 1'b0;
                    n_seen_cr   = 1'b0;
                    n_line_bad  = 1'b0;
                end else begin
                    n_skip = 1'b1;
                end
            end
            PH_DONE, PH_ERR: begin
            end
            default: begin
            end
        endcase

        o_result.out_byte      = pv ? c : 8'd0;
        o_result.payload_valid = pv;
        o_result.chunk_last    = last;
        if (n_phase == PH_DONE) begin
            o_result.status = ST_DONE;
        end else if (n_phase == PH_ERR) begin
            o_result.status = ST_ERR;
        end else begin
            o_result.status = ST_BUSY;
        end
    end

endmodule

[sv/chb_out_stage.sv]
`timescale 1ns / 1ps
// ============================================================================
// chb_out_stage
// Result register driving the output channel.
// ============================================================================
module chb_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  chb_pkg::t_result i_result,
    output logic             o_free,
    chb_out_if.source        o_out
);
    import chb_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Free when empty or when the held result leaves this cycle
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.out_byte      = r_result.out_byte;
    assign o_out.payload_valid = r_result.payload_valid;
    assign o_out.chunk_last    = r_result.chunk_last;
    assign o_out.status        = r_result.status;

endmodule

[sv/http_chunked_body_decoder.sv]
`timescale 1ns / 1ps
// ============================================================================
// http_chunked_body_decoder
// Decodes an HTTP chunked body one byte per request, one result per byte.
// ============================================================================
//  Channel  Dir  Payload                                    Handshake
//  i_in     in   in_byte[7:0], new_body                     valid/ready
//  o_out    out  out_byte[7:0], payload_valid, chunk_last,  valid/ready
//                status[1:0]
//
//  One byte per cycle sustained while the output is not stalled; an accepted
//  byte is held in the input register and then, with the parser update, is
//  registered in the result register, from which its result is taken.
//  The parser state advances only when the held byte moves into the result
//  register, so a stalled output holds both stages and ready drops.
//  Synchronous active-low reset empties both stages and sets the size-line
//  phase; no clearing pass is needed.
// ============================================================================
module http_chunked_body_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    chb_in_if.sink    i_in,
    chb_out_if.source o_out
);
    import chb_pkg::*;

    logic    in_valid;
    t_item   in_item;
    t_result result;
    logic    out_free;
    logic    advance;

    // Byte moves from input register to result register
    assign advance = in_valid && out_free;

    chb_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    chb_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (in_item),
        .o_result (result)
    );

    chb_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (result),
        .o_free   (out_free),
        .o_out    (o_out)
    );

endmodule

[sv/chb_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// chb_checker
// Port-level checks on the decoder's result channel.
// ============================================================================
module chb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_out_byte,
    input logic       i_payload_valid,
    input logic       i_chunk_last,
    input logic [1:0] i_status
);
    import chb_pkg::*;

    // A stalled result stays valid and keeps its byte, status and payload flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_out_byte)
            && $stable(i_status) && $stable(i_payload_valid)))
        else $error("stalled result changed");

    // End of chunk only on a payload byte
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_chunk_last) |-> i_payload_valid)
        else $error("chunk_last without payload");

    // Payload never coexists with a finished or failed body
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_payload_valid) |-> (i_status == ST_BUSY))
        else $error("payload with done or error status");

    // Non-payload results carry a zero byte
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_payload_valid) |-> (i_out_byte == 8'd0))
        else $error("non-payload result has nonzero byte");

endmodule

bind http_chunked_body_decoder chb_checker u_chb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_out.valid),
    .i_ready         (o_out.ready),
    .i_out_byte      (o_out.out_byte),
    .i_payload_valid (o_out.payload_valid),
    .i_chunk_last    (o_out.chunk_last),
    .i_status        (o_out.status)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives chunked HTTP bodies into http_chunked_body_decoder byte by byte:
// a short directed set of size lines (empty, zero, stray CR, bad character,
// overflow, end of body) and then random bodies, mostly well-formed with some
// spoiled lines. Each result is checked against a cycle-free decoder model
// kept in a scoreboard, under three sender/receiver stall mixes.
// ============================================================================
module testbench;
    import chb_pkg::*;

    // Run length and stall mixes
    localparam int CYCLE_LIMIT   = 200000;
    localparam int ITEMS_PER_MIX = 135;
    localparam int DRAIN_CYCLES  = 8;

    // Ways a random size line gets spoiled
    typedef enum int {
        FLAW_NONE,
        FLAW_EMPTY,
        FLAW_ZERO,
        FLAW_BAD_CHAR,
        FLAW_STRAY_CR,
        FLAW_OVERFLOW,
        FLAW_OPEN
    } t_flaw;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the decoder state per accepted request and holds the
    // decoded results still due from the block.
    // ------------------------------------------------------------------------
    class chunk_scoreboard;
        t_phase     ph;
        t_size      accum;
        logic [1:0] len;
        bit         zero_only;
        bit         cr_seen;
        bit         bad;
        t_size      left;
        logic [1:0] skipped;
        t_result    decoded_q[$];
        int         errors;

        function new();
            errors = 0;
            restart_body();
        endfunction

        function void clear_line();
            accum     = '0;
            len       = '0;
            zero_only = 0;
            cr_seen   = 0;
            bad       = 0;
        endfunction

        function void restart_body();
            ph      = PH_SIZE;
            left    = '0;
            skipped = '0;
            clear_line();
        endfunction

        function void hex_digit(input logic [7:0] c, output bit ok, output logic [3:0] nib);
            ok  = 1;
            nib = '0;
            if (c inside {[8'h30:8'h39]}) begin
                nib = c[3:0];
            end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
                nib = c[3:0] + 4'd9;
            end else begin
                ok = 0;
            end
        endfunction

        // CR LF seen: decide between data, end of body and error
        function void close_line();
            if (len == 0 || bad) begin
                ph = PH_ERR;
            end else if (zero_only) begin
                ph = PH_DONE;
            end else if (accum == 0) begin
                ph = PH_ERR;
            end else begin
                left = accum;
                ph   = PH_DATA;
            end
            clear_line();
        endfunction

        function void size_line_byte(logic [7:0] c);
            bit         is_hex;
            logic [3:0] nib;
            if (cr_seen) begin
                if (c == CHAR_LF) begin
                    close_line();
                    return;
                end
                bad = 1;
            end
            if (c == CHAR_CR) begin
                cr_seen = 1;
                return;
            end
            cr_seen = 0;
            hex_digit(c, is_hex, nib);
            zero_only = (len == 0) && (c == CHAR_ZERO);
            if (len != LINE_LEN_MAX) len++;
            if (!is_hex) begin
                bad = 1;
            end else if (accum[SIZE_BITS-1 -: 4] != 0) begin
                bad = 1;
            end else begin
                accum = {accum[SIZE_BITS-5:0], nib};
            end
        endfunction

        function t_result decode_byte(t_item it);
            t_result r;
            r = '0;
            if (it.new_body) restart_body();
            case (ph)
                PH_SIZE: begin
                    size_line_byte(it.in_byte);
                end
                PH_DATA: begin
                    r.out_byte      = it.in_byte;
                    r.payload_valid = 1'b1;
                    if (left != 0) left--;
                    if (left == 0) begin
                        r.chunk_last = 1'b1;
                        ph           = PH_SKIP;
                        skipped      = '0;
                    end
                end
                PH_SKIP: begin
                    skipped++;
                    if (skipped >= 2) begin
                        skipped = '0;
                        ph      = PH_SIZE;
                        clear_line();
                    end
                end
                default: ;
            endcase
            if (ph == PH_DONE)     r.status = ST_DONE;
            else if (ph == PH_ERR) r.status = ST_ERR;
            else                   r.status = ST_BUSY;
            return r;
        endfunction

        function void note_request(t_item it);
            decoded_q.push_back(decode_byte(it));
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result, actual %0h", $time, got);
                errors++;
                return;
            end
            want = decoded_q.pop_front();
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("payload_valid", 8'(want.payload_valid), 8'(got.payload_valid));
            compare_field("chunk_last", 8'(want.chunk_last), 8'(got.chunk_last));
            compare_field("status", 8'(want.status), 8'(got.status));
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    chb_in_if  in_if();
    chb_out_if out_if();

    http_chunked_body_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    chunk_scoreboard board;
    int send_gap_pct;
    int recv_gap_pct;
    int sent_count;
    int cycle_count;
    bit body_start;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random back-pressure, check every accepted result
    initial begin
        t_result got;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.out_byte      = out_if.out_byte;
                got.payload_valid = out_if.payload_valid;
                got.chunk_last    = out_if.chunk_last;
                got.status        = out_if.status;
                board.check_result(got);
            end
            out_if.ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // One request; new_body rides on the first byte of a body
    task automatic push_byte(input logic [7:0] b);
        t_item it;
        while ($urandom_range(99) < send_gap_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        it.in_byte      = b;
        it.new_body     = body_start;
        body_start      = 0;
        in_if.valid    <= 1'b1;
        in_if.in_byte  <= it.in_byte;
        in_if.new_body <= it.new_body;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        board.note_request(it);
        sent_count++;
    endtask

    task automatic push_crlf();
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    // Hex text of a size, random letter case, sometimes a leading zero
    function automatic string size_text(input int unsigned v);
        string s;
        s = $sformatf("%0h", v);
        for (int i = 0; i < s.len(); i++) begin
            if (s[i] >= 8'h61 && $urandom_range(1)) s[i] = s[i] - 8'h20;
        end
        if ($urandom_range(3) == 0) s = {"0", s};
        return s;
    endfunction

    task automatic send_size_line(input int unsigned sz, input t_flaw flaw);
        string text;
        int    pos;
        text = size_text(sz);
        case (flaw)
            FLAW_NONE: begin
                send_text(text);
                push_crlf();
            end
            FLAW_EMPTY: begin
                push_crlf();
            end
            FLAW_ZERO: begin
                send_text("00");
                push_crlf();
            end
            FLAW_BAD_CHAR: begin
                pos = $urandom_range(text.len());
                for (int i = 0; i < text.len(); i++) begin
                    if (i == pos) push_byte(8'($urandom_range(255)));
                    push_byte(text[i]);
                end
                if (pos == text.len()) push_byte(8'($urandom_range(255)));
                push_crlf();
            end
            FLAW_STRAY_CR: begin
                send_text(text);
                push_byte(CHAR_CR);
                push_byte(8'($urandom_range(255)));
                push_crlf();
            end
            FLAW_OVERFLOW: begin
                send_text(size_text($urandom_range(15, 1)));
                send_text(size_text($urandom | 32'h1000_0000));
                push_crlf();
            end
            default: begin
                // line left open; the next body restarts the decoder
                send_text(text);
            end
        endcase
    endtask

    // A random body: a few chunks and the closing zero line, maybe spoiled
    task automatic send_body(input bit spoiled);
        int          n_chunks;
        int          flaw_at;
        int unsigned sz;
        body_start = 1;
        n_chunks   = $urandom_range(3, 1);
        flaw_at    = spoiled ? $urandom_range(n_chunks) : -1;
        for (int k = 0; k <= n_chunks; k++) begin
            if (k == flaw_at) begin
                send_size_line($urandom_range(6, 1),
                               t_flaw'($urandom_range(FLAW_OPEN, FLAW_EMPTY)));
                repeat ($urandom_range(2)) push_byte(8'($urandom_range(255)));
                return;
            end
            if (k == n_chunks) begin
                send_text("0");
                push_crlf();
            end else begin
                sz = ($urandom_range(15) == 0) ? $urandom_range(80, 16) : $urandom_range(6, 1);
                send_size_line(sz, FLAW_NONE);
                repeat (sz) push_byte(8'($urandom_range(255)));
                if ($urandom_range(3) == 0) begin
                    push_byte(8'($urandom_range(255)));
                    push_byte(8'($urandom_range(255)));
                end else begin
                    push_crlf();
                end
            end
        end
        // bytes after the end of body are ignored
        if ($urandom_range(3) == 0) push_byte(8'($urandom_range(255)));
    endtask

    task automatic send_random_bodies(input int until_count);
        while (sent_count < until_count) send_body($urandom_range(3) == 0);
    endtask

    // Main sequence
    initial begin
        board        = new();
        sent_count   = 0;
        body_start   = 0;
        send_gap_pct = 8;
        recv_gap_pct = 68;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.in_byte   <= '0;
        in_if.new_body  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Two-byte chunk with extreme payload, end of body, ignored byte
        body_start = 1;
        send_text("2");
        push_crlf();
        push_byte(8'h00);
        push_byte(8'hFF);
        push_crlf();
        send_text("0");
        push_crlf();
        push_byte(8'hFF);
        // Empty size line
        body_start = 1;
        push_crlf();
        // Zero value that is not a lone "0"
        body_start = 1;
        send_text("00");
        push_crlf();
        // Stray CR inside the line
        body_start = 1;
        send_text("1");
        push_byte(CHAR_CR);
        send_text("x");
        push_crlf();
        // Value wider than the size field, mixed case
        body_start = 1;
        send_text("fFfFfFfFf");
        push_crlf();
        // Non-hex character
        body_start = 1;
        send_text("g");
        push_crlf();

        send_random_bodies(ITEMS_PER_MIX);
        send_gap_pct = 68;
        recv_gap_pct = 8;
        send_random_bodies(2 * ITEMS_PER_MIX);
        send_gap_pct = 0;
        recv_gap_pct = 0;
        send_random_bodies(3 * ITEMS_PER_MIX);
        in_if.valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[http_chunked_body_decoder.f]
sv/chb_pkg.sv
sv/chb_ifs.sv
sv/chb_in_stage.sv
sv/chb_parser.sv
sv/chb_out_stage.sv
sv/http_chunked_body_decoder.sv
sv/chb_checker.sv
tb/sv/testbench.sv
